// ===== hw/rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes, types and helper functions of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 17;
  localparam int COUNT_W    = 11;
  localparam int ALIGN_W    = 13;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // pool span in bytes: effective count times effective block size
  localparam int SPAN_W     = CNT_W + BYTES_W;

  // divider retires two quotient bits per cycle
  localparam int DIV_STEPS  = (IDX_W + 1) / 2;
  localparam int QUOT_W     = 2 * DIV_STEPS;
  localparam int DIVR_W     = BYTES_W + QUOT_W - 1;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // command queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd3;

  localparam logic [ADDR_W-1:0]  RST_BASE  = 32'd0;
  localparam logic [BYTES_W-1:0] RST_BYTES = 17'd64;
  localparam logic [COUNT_W-1:0] RST_COUNT = 11'd1024;
  localparam logic [ALIGN_W-1:0] RST_ALIGN = 13'd8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_BAD_ALIGN    = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_NOT_START    = 3'd5,
    ST_ALREADY_FREE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REFUSE
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    status_t            status;
    logic [SPAN_W-1:0]  off;
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   count;
    logic [ALIGN_W-1:0] align;
    logic [SPAN_W-1:0]  span;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic             exact;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > 32'(MAX_BLOCKS)) begin
      r = CNT_W'(MAX_BLOCKS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
    return (b == '0) ? BYTES_W'(1) : b;
  endfunction

  function automatic logic [ALIGN_W-1:0] eff_align(input logic [ALIGN_W-1:0] a);
    return (a == '0) ? ALIGN_W'(1) : a;
  endfunction

endpackage

// ===== hw/rtl/fbpa_channels.sv =====
// ----------------------------------------------------------------------------
// fbpa_channels
// Valid/ready channels of the allocator: request in, response out.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [fbpa_pkg::BYTES_W-1:0]    req_bytes;
  logic [fbpa_pkg::ALIGN_W-1:0]    req_align;
  logic [fbpa_pkg::ADDR_W-1:0]     block_address;

  modport source (output valid, cmd, req_bytes, req_align, block_address, input ready);
  modport sink   (input valid, cmd, req_bytes, req_align, block_address, output ready);
endinterface

interface fbpa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fbpa_pkg::ADDR_W-1:0]     grant_address;
  logic [fbpa_pkg::STATUS_W-1:0]   status;
  logic [fbpa_pkg::COUNT_W-1:0]    free_count;

  modport source (output valid, grant_address, status, free_count, input ready);
  modport sink   (input valid, grant_address, status, free_count, output ready);
endinterface

// ===== hw/rtl/fbpa_front.sv =====
// ----------------------------------------------------------------------------
// fbpa_front
// Request holding register and classifier: alignment, size and range checks.
// ----------------------------------------------------------------------------
module fbpa_front (
  input  logic                clk,
  input  logic                rst_n,
  fbpa_req_if.sink            req,
  input  fbpa_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                push,
  output fbpa_pkg::op_t       op
);

  logic                             hold_v_r;
  logic                             cmd_r;
  logic [fbpa_pkg::BYTES_W-1:0]     bytes_r;
  logic [fbpa_pkg::ALIGN_W-1:0]     align_r;
  logic [fbpa_pkg::ADDR_W-1:0]      addr_r;

  logic                             pow2;
  logic [fbpa_pkg::ADDR_W-1:0]      off;

  assign req.ready = !hold_v_r || !q_full;
  assign push      = hold_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (req.ready) begin
      hold_v_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r   <= req.cmd;
      bytes_r <= req.req_bytes;
      align_r <= req.req_align;
      addr_r  <= req.block_address;
    end
  end

  assign pow2 = (align_r != '0) &&
                ((align_r & (align_r - fbpa_pkg::ALIGN_W'(1))) == '0);
  assign off  = addr_r - cfg.base;

  always_comb begin
    op.kind   = fbpa_pkg::OP_REFUSE;
    op.status = fbpa_pkg::ST_OK;
    op.off    = off[fbpa_pkg::SPAN_W-1:0];
    if (cmd_r == fbpa_pkg::CMD_ALLOC) begin
      if (!pow2 || align_r > cfg.align) begin
        op.status = fbpa_pkg::ST_BAD_ALIGN;
      end else if (bytes_r > cfg.bytes) begin
        op.status = fbpa_pkg::ST_TOO_LARGE;
      end else begin
        op.kind = fbpa_pkg::OP_ALLOC;
      end
    end else begin
      // end bound is exclusive
      if (addr_r < cfg.base || off >= fbpa_pkg::ADDR_W'(cfg.span)) begin
        op.status = fbpa_pkg::ST_OUT_OF_RANGE;
      end else begin
        op.kind = fbpa_pkg::OP_FREE;
      end
    end
  end

endmodule

// ===== hw/rtl/fbpa_queue.sv =====
// ----------------------------------------------------------------------------
// fbpa_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module fbpa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbpa_pkg::op_t       push_op,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output fbpa_pkg::op_t       head_op
);

  fbpa_pkg::op_t                    slot_r [fbpa_pkg::Q_DEPTH];
  logic [fbpa_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [fbpa_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [fbpa_pkg::Q_CNT_W-1:0]     fill_r;

  assign full    = (fill_r == fbpa_pkg::Q_CNT_W'(fbpa_pkg::Q_DEPTH));
  assign valid   = (fill_r != '0);
  assign head_op = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fbpa_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fbpa_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + fbpa_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - fbpa_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== hw/rtl/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, two quotient bits per cycle: pool offset by block size.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fbpa_pkg::SPAN_W-1:0]   dividend,
  input  logic [fbpa_pkg::BYTES_W-1:0]  divisor,
  output fbpa_pkg::div_rsp_t            rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [fbpa_pkg::STEP_W-1:0]      step_r;
  logic [fbpa_pkg::SPAN_W-1:0]      rem_r;
  logic [fbpa_pkg::DIVR_W-1:0]      d_r;
  logic [fbpa_pkg::QUOT_W-1:0]      q_r;

  logic [fbpa_pkg::SPAN_W-1:0]      d_hi;
  logic [fbpa_pkg::SPAN_W-1:0]      d_lo;
  logic                             take_hi;
  logic                             take_lo;
  logic [fbpa_pkg::SPAN_W-1:0]      rem_mid;
  logic [fbpa_pkg::SPAN_W-1:0]      rem_end;

  // quotient is known to fit: offset is below the pool span
  assign d_hi    = fbpa_pkg::SPAN_W'(d_r);
  assign d_lo    = fbpa_pkg::SPAN_W'(d_r >> 1);
  assign take_hi = (rem_r >= d_hi);
  assign rem_mid = take_hi ? (rem_r - d_hi) : rem_r;
  assign take_lo = (rem_mid >= d_lo);
  assign rem_end = take_lo ? (rem_mid - d_lo) : rem_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == fbpa_pkg::STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= fbpa_pkg::STEP_W'(fbpa_pkg::DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - fbpa_pkg::STEP_W'(1);
        if (step_r == fbpa_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      d_r   <= fbpa_pkg::DIVR_W'(divisor) << (fbpa_pkg::QUOT_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_end;
      d_r   <= d_r >> 2;
      q_r   <= (q_r << 2) | fbpa_pkg::QUOT_W'({take_hi, take_lo});
    end
  end

  assign rsp.done  = done_r;
  assign rsp.quot  = q_r[fbpa_pkg::IDX_W-1:0];
  assign rsp.exact = (rem_r == '0);

endmodule

// ===== hw/rtl/fbpa_back.sv =====
// ----------------------------------------------------------------------------
// fbpa_back
// Executes allocate and free requests on the free list and the free marks.
// ----------------------------------------------------------------------------
module fbpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fbpa_pkg::cfg_t      cfg,
  input  logic                init,
  input  logic                q_valid,
  input  fbpa_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                div_start,
  input  fbpa_pkg::div_rsp_t  div_rsp,
  fbpa_rsp_if.source          rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_DIV,
    S_FREE
  } state_t;

  state_t                                       state_r;
  logic [fbpa_pkg::IDX_W-1:0]                   head_r;
  logic [fbpa_pkg::IDX_W-1:0]                   tail_r;
  logic [fbpa_pkg::CNT_W-1:0]                   free_r;
  // blocks taken from the initial ascending run since the last init
  logic [fbpa_pkg::CNT_W-1:0]                   fresh_r;
  logic [fbpa_pkg::IDX_W-1:0]                   idx_r;

  logic                                         out_valid_r;
  logic                                         out_valid_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]                  grant_r;
  fbpa_pkg::status_t                            status_r;
  logic [fbpa_pkg::COUNT_W-1:0]                 fcount_r;

  logic [fbpa_pkg::IDX_W-1:0]                   next_mem [fbpa_pkg::MAX_BLOCKS];
  logic                                         mark_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0]                   next_rd_r;
  logic                                         mark_rd_r;

  logic                                         out_free;
  logic                                         rsp_load;
  logic [fbpa_pkg::IDX_W+fbpa_pkg::BYTES_W-1:0] prod;
  logic [fbpa_pkg::ADDR_W-1:0]                  grant_sum;
  logic                                         head_is_fresh;
  logic                                         mark_now;
  logic                                         next_we;
  logic                                         mark_we;
  logic [fbpa_pkg::IDX_W-1:0]                   mark_wa;
  logic                                         mark_wd;

  assign out_free  = !out_valid_r || rsp.ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid && out_free && !init;
  assign div_start = q_pop && (q_op.kind == fbpa_pkg::OP_FREE);

  // a response is loaded on an immediate refusal at pop or at the end of execution
  assign rsp_load = (q_pop && (q_op.kind != fbpa_pkg::OP_FREE) &&
                     !((q_op.kind == fbpa_pkg::OP_ALLOC) && (free_r != '0))) ||
                    (!init && ((state_r == S_ALLOC) || (state_r == S_FREE) ||
                               ((state_r == S_DIV) && div_rsp.done && !div_rsp.exact)));
  assign out_valid_nxt = rsp_load || (out_valid_r && !rsp.ready);

  assign prod      = head_r * cfg.bytes;
  assign grant_sum = cfg.base + fbpa_pkg::ADDR_W'(prod);

  // untouched part of the initial run links to the next index
  assign head_is_fresh = (fresh_r < (cfg.count - fbpa_pkg::CNT_W'(1)));
  // blocks at or past the fresh point were never handed out: still free
  assign mark_now      = (fbpa_pkg::CNT_W'(idx_r) >= fresh_r) || mark_rd_r;

  assign mark_we = (state_r == S_ALLOC) || ((state_r == S_FREE) && !mark_now);
  assign mark_wa = (state_r == S_ALLOC) ? head_r : idx_r;
  assign mark_wd = (state_r != S_ALLOC);
  assign next_we = (state_r == S_FREE) && !mark_now && (free_r != '0);

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[tail_r] <= idx_r;
    end
    next_rd_r <= next_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd_r <= mark_mem[div_rsp.quot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= fbpa_pkg::IDX_W'(fbpa_pkg::eff_count(fbpa_pkg::RST_COUNT) -
                                      fbpa_pkg::CNT_W'(1));
      free_r      <= fbpa_pkg::eff_count(fbpa_pkg::RST_COUNT);
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (init) begin
        state_r <= S_IDLE;
        head_r  <= '0;
        tail_r  <= fbpa_pkg::IDX_W'(cfg.count - fbpa_pkg::CNT_W'(1));
        free_r  <= cfg.count;
        fresh_r <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (q_pop) begin
              unique case (q_op.kind)
                fbpa_pkg::OP_ALLOC: begin
                  if (free_r == '0) begin
                    grant_r     <= '0;
                    status_r    <= fbpa_pkg::ST_EMPTY;
                    fcount_r    <= fbpa_pkg::COUNT_W'(free_r);
                  end else begin
                    state_r <= S_ALLOC;
                  end
                end
                fbpa_pkg::OP_FREE: begin
                  state_r <= S_DIV;
                end
                default: begin
                  grant_r     <= '0;
                  status_r    <= q_op.status;
                  fcount_r    <= fbpa_pkg::COUNT_W'(free_r);
                end
              endcase
            end
          end
          S_ALLOC: begin
            head_r <= head_is_fresh ? (head_r + fbpa_pkg::IDX_W'(1)) : next_rd_r;
            if (fresh_r < cfg.count) begin
              fresh_r <= fresh_r + fbpa_pkg::CNT_W'(1);
            end
            free_r      <= free_r - fbpa_pkg::CNT_W'(1);
            grant_r     <= grant_sum;
            status_r    <= fbpa_pkg::ST_OK;
            fcount_r    <= fbpa_pkg::COUNT_W'(free_r - fbpa_pkg::CNT_W'(1));
            state_r     <= S_IDLE;
          end
          S_DIV: begin
            if (div_rsp.done) begin
              if (!div_rsp.exact) begin
                grant_r     <= '0;
                status_r    <= fbpa_pkg::ST_NOT_START;
                fcount_r    <= fbpa_pkg::COUNT_W'(free_r);
                state_r     <= S_IDLE;
              end else begin
                idx_r   <= div_rsp.quot;
                state_r <= S_FREE;
              end
            end
          end
          S_FREE: begin
            grant_r     <= '0;
            if (mark_now) begin
              status_r <= fbpa_pkg::ST_ALREADY_FREE;
              fcount_r <= fbpa_pkg::COUNT_W'(free_r);
            end else begin
              // append at the tail; an empty list restarts at this block
              if (free_r == '0) begin
                head_r <= idx_r;
              end
              tail_r   <= idx_r;
              free_r   <= free_r + fbpa_pkg::CNT_W'(1);
              status_r <= fbpa_pkg::ST_OK;
              fcount_r <= fbpa_pkg::COUNT_W'(free_r + fbpa_pkg::CNT_W'(1));
            end
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign rsp.valid         = out_valid_r;
  assign rsp.grant_address = grant_r;
  assign rsp.status        = status_r;
  assign rsp.free_count    = fcount_r;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool with a FIFO free list, allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request per valid/ready handshake: cmd 0 allocates a
//          block (req_bytes, req_align checked), cmd 1 frees block_address.
//   out_ch returns exactly one response per request, in order: grant
//          address, status code and the free block count after the request.
//   cfg_*  writes one of four registers (base, block size, block count,
//          pool alignment); any write rebuilds the pool with all blocks free
//          in ascending order. Write only while no request is in flight.
// Flow:
//   An allocate is popped from the queue into the execute stage, which
//   then takes the head block. A free holds the execute stage while the
//   block-index divider, retiring two quotient bits per cycle, finds the
//   block, then checks its free mark. Requests refused before execution
//   respond on the pop, a free off a block start when the divider ends.
//   The front stage and a two-entry queue keep accepting requests meanwhile.
// Reset and stalls:
//   After reset the registers hold their defaults and all blocks are free.
//   When out_ch is stalled the response holds; requests back up through the
//   queue and in_ch drops ready once the front stage and queue are full.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  fbpa_req_if.sink                            in_ch,
  fbpa_rsp_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [fbpa_pkg::ADDR_W-1:0]    base_r;
  logic [fbpa_pkg::BYTES_W-1:0]   bytes_r;
  logic [fbpa_pkg::COUNT_W-1:0]   count_r;
  logic [fbpa_pkg::ALIGN_W-1:0]   align_r;
  logic                           init_r;
  logic [fbpa_pkg::SPAN_W-1:0]    span_r;

  logic [fbpa_pkg::BYTES_W-1:0]   eff_bytes;
  logic [fbpa_pkg::CNT_W-1:0]     eff_count;
  fbpa_pkg::cfg_t                 cfg;

  logic                           push;
  fbpa_pkg::op_t                  push_op;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_valid;
  fbpa_pkg::op_t                  q_op;
  logic                           div_start;
  fbpa_pkg::div_rsp_t             div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= fbpa_pkg::RST_BASE;
      bytes_r <= fbpa_pkg::RST_BYTES;
      count_r <= fbpa_pkg::RST_COUNT;
      align_r <= fbpa_pkg::RST_ALIGN;
      init_r  <= 1'b0;
    end else begin
      // rebuild the pool in the cycle after any register write
      init_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          fbpa_pkg::CFG_BASE:  base_r  <= cfg_wdata[fbpa_pkg::ADDR_W-1:0];
          fbpa_pkg::CFG_BYTES: bytes_r <= cfg_wdata[fbpa_pkg::BYTES_W-1:0];
          fbpa_pkg::CFG_COUNT: count_r <= cfg_wdata[fbpa_pkg::COUNT_W-1:0];
          fbpa_pkg::CFG_ALIGN: align_r <= cfg_wdata[fbpa_pkg::ALIGN_W-1:0];
        endcase
      end
    end
  end

  assign eff_bytes = fbpa_pkg::eff_bytes(bytes_r);
  assign eff_count = fbpa_pkg::eff_count(count_r);

  always_ff @(posedge clk) begin
    span_r <= fbpa_pkg::SPAN_W'(eff_count) * fbpa_pkg::SPAN_W'(eff_bytes);
  end

  assign cfg.base  = base_r;
  assign cfg.bytes = eff_bytes;
  assign cfg.count = eff_count;
  assign cfg.align = fbpa_pkg::eff_align(align_r);
  assign cfg.span  = span_r;

  fbpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .op      (push_op)
  );

  fbpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (q_op)
  );

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_op.off),
    .divisor  (eff_bytes),
    .rsp      (div_rsp)
  );

  fbpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .init      (init_r),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .div_start (div_start),
    .div_rsp   (div_rsp),
    .rsp       (out_ch)
  );

endmodule
